/* hw/rtl/cfk_pkg.sv */
// Shared types, constants and helpers for the caliper frame to key report block.
`default_nettype none

package cfk_pkg;

  localparam int unsigned MAG_W      = 20;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_CELLS  = 6;
  localparam int unsigned INCH_KEYS  = 13;
  localparam int unsigned METRIC_KEYS = 11;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned CNT_W      = 4;

  // ceil(2^23 / 10); exact quotient for any value below 2^22
  localparam logic [MAG_W-1:0] RECIP_TEN = 20'd838861;
  localparam int unsigned      RECIP_SH  = 23;

  localparam logic [MAG_W-1:0] MAX_VALUE_RST = 20'd15500;

  localparam logic [KEY_W-1:0] KEY_NONE   = 8'h00;
  localparam logic [KEY_W-1:0] KEY_DASH   = 8'h38;
  localparam logic [KEY_W-1:0] KEY_DECSEP = 8'h36;
  localparam logic [KEY_W-1:0] KEY_GAP    = 8'h2C;
  localparam logic [KEY_W-1:0] KEY_RETURN = 8'h28;
  localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h27;
  localparam logic [KEY_W-1:0] KEY_ONE   = 8'h1E;
  localparam logic [KEY_W-1:0] KEY_A     = 8'h04;
  localparam logic [KEY_W-1:0] KEY_M     = KEY_A + 8'd12;
  localparam logic [KEY_W-1:0] KEY_L     = KEY_A + 8'd11;
  localparam logic [KEY_W-1:0] KEY_O     = KEY_A + 8'd14;
  localparam logic [KEY_W-1:0] KEY_Z     = KEY_A + 8'd24;
  localparam logic [KEY_W-1:0] KEY_FIVE  = KEY_ONE + 8'd4;

  localparam logic REG_MAX_VALUE = 1'b0;
  localparam logic REG_MODIFIER  = 1'b1;

  typedef struct packed {
    logic [MAG_W-1:0]                    w;
    logic [NUM_CELLS-1:0][DIGIT_W-1:0]   dig;
    logic [NUM_CELLS-1:0]                nz;
    logic                                neg;
    logic                                inch;
    logic                                odd;
    logic                                rej;
  } conv_t;

  function automatic logic [KEY_W-1:0] digit_key(input logic [DIGIT_W-1:0] d);
    logic [KEY_W-1:0] code;
    if (d == '0) begin
      code = KEY_ZERO;
    end else begin
      code = KEY_ONE + {{(KEY_W-DIGIT_W){1'b0}}, d} - 8'd1;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/caliper_frame_to_key_reports.sv */
// Top level: caliper frame to HID key report converter.
// Each frame (two 12-bit halves) is range checked, then passes an input register and a row
// of six digit cells that split the magnitude into decimal digits; a frame can enter every
// cycle while earlier ones are still in the row, unless frame_stall holds it. The serializer
// then sends 22 reports for a metric frame and 26 for an inch frame, one per cycle unless
// report_stall holds the output, and a single flagged report for a rejected frame; it takes
// the next frame as the last report of the current one enters the output register. The
// configuration registers are written through cfg_valid/cfg_ready (always ready), index 0
// max_value and index 1 modifier_byte; the user must write them only while no frame is in
// flight, and the block itself does not enforce it.
`default_nettype none

module caliper_frame_to_key_reports (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        frame_valid,
  output logic             frame_stall,
  input  wire logic [11:0] frame_low,
  input  wire logic [11:0] frame_high,
  output logic             report_valid,
  input  wire logic        report_stall,
  output logic [7:0]       key_code,
  output logic [7:0]       report_modifier,
  output logic             frame_rejected,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_data
);

  logic [cfk_pkg::MAG_W-1:0] max_value;
  logic [cfk_pkg::KEY_W-1:0] modifier_byte;

  logic [23:0]               word;
  logic [cfk_pkg::MAG_W-1:0] mag;
  cfk_pkg::conv_t            item_in;

  logic           valid [cfk_pkg::NUM_CELLS+1];
  cfk_pkg::conv_t item  [cfk_pkg::NUM_CELLS+1];
  logic           stall [cfk_pkg::NUM_CELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value     <= cfk_pkg::MAX_VALUE_RST;
      modifier_byte <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfk_pkg::REG_MAX_VALUE: max_value     <= cfg_data;
        cfk_pkg::REG_MODIFIER:  modifier_byte <= cfg_data[cfk_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    word         = {frame_high, frame_low};
    mag          = word[cfk_pkg::MAG_W-1:0];
    item_in      = '0;
    item_in.neg  = word[20];
    item_in.inch = word[23];
    item_in.odd  = mag[0];
    item_in.rej  = (word[22:21] != 2'b00) || (mag > max_value);
    item_in.w    = word[23] ? (mag >> 1) : mag;
  end

  assign frame_stall = valid[0] && stall[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (!frame_stall) begin
      valid[0] <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall) begin
      item[0] <= item_in;
    end
  end

  for (genvar k = 0; k < cfk_pkg::NUM_CELLS; k++) begin : g_cell
    cfk_digit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[k]),
      .up_item  (item[k]),
      .up_stall (stall[k]),
      .dn_valid (valid[k+1]),
      .dn_item  (item[k+1]),
      .dn_stall (stall[k+1])
    );
  end

  cfk_report_ser u_ser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (valid[cfk_pkg::NUM_CELLS]),
    .in_item         (item[cfk_pkg::NUM_CELLS]),
    .in_stall        (stall[cfk_pkg::NUM_CELLS]),
    .modifier_byte   (modifier_byte),
    .out_valid       (report_valid),
    .out_stall       (report_stall),
    .key_code        (key_code),
    .report_modifier (report_modifier),
    .frame_rejected  (frame_rejected),
    .last            (last)
  );

endmodule

`default_nettype wire

/* hw/rtl/cfk_digit_cell.sv */
// One decimal digit cell: peels the low digit off the value and passes the rest on.
`default_nettype none

module cfk_digit_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  input  wire cfk_pkg::conv_t up_item,
  output logic               up_stall,
  output logic               dn_valid,
  output cfk_pkg::conv_t     dn_item,
  input  wire logic          dn_stall
);

  logic [2*cfk_pkg::MAG_W-1:0] prod;
  logic [cfk_pkg::MAG_W-1:0]   quot;
  logic [cfk_pkg::MAG_W-1:0]   rem;
  cfk_pkg::conv_t              item_next;

  assign up_stall = dn_valid && dn_stall;

  always_comb begin
    prod = {{cfk_pkg::MAG_W{1'b0}}, up_item.w} *
           {{cfk_pkg::MAG_W{1'b0}}, cfk_pkg::RECIP_TEN};
    quot = cfk_pkg::MAG_W'(prod >> cfk_pkg::RECIP_SH);
    rem  = up_item.w - (quot << 3) - (quot << 1);
    item_next     = up_item;
    item_next.w   = quot;
    item_next.dig = {rem[cfk_pkg::DIGIT_W-1:0], up_item.dig[cfk_pkg::NUM_CELLS-1:1]};
    item_next.nz  = {(up_item.w != '0), up_item.nz[cfk_pkg::NUM_CELLS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      dn_item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cfk_report_ser.sv */
// Key layout and report serializer with the output register.
`default_nettype none

module cfk_report_ser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire cfk_pkg::conv_t               in_item,
  output logic                              in_stall,
  input  wire logic [cfk_pkg::KEY_W-1:0]    modifier_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [cfk_pkg::KEY_W-1:0]         key_code,
  output logic [cfk_pkg::KEY_W-1:0]         report_modifier,
  output logic                              frame_rejected,
  output logic                              last
);

  logic                      busy;
  logic                      rej_q;
  logic                      phase;
  logic [cfk_pkg::CNT_W-1:0] remain;
  logic [cfk_pkg::INCH_KEYS-1:0][cfk_pkg::KEY_W-1:0] keys;
  logic [cfk_pkg::INCH_KEYS-1:0][cfk_pkg::KEY_W-1:0] keys_new;
  logic                      adv;
  logic                      finishing;
  logic                      load;
  logic [cfk_pkg::KEY_W-1:0] lead;

  assign adv       = !out_valid || !out_stall;
  assign finishing = busy && adv && (rej_q || (phase && remain == '0));
  assign in_stall  = busy && !finishing;
  assign load      = in_valid && !in_stall;

  always_comb begin
    keys_new = '0;
    if (in_item.neg) begin
      lead = cfk_pkg::KEY_DASH;
    end else if (in_item.inch ? in_item.nz[4] : in_item.nz[5]) begin
      lead = cfk_pkg::digit_key(in_item.inch ? in_item.dig[4] : in_item.dig[5]);
    end else begin
      lead = cfk_pkg::KEY_NONE;
    end
    keys_new[0] = lead;
    if (in_item.inch) begin
      keys_new[1]  = cfk_pkg::digit_key(in_item.dig[3]);
      keys_new[2]  = cfk_pkg::KEY_DECSEP;
      keys_new[3]  = cfk_pkg::digit_key(in_item.dig[2]);
      keys_new[4]  = cfk_pkg::digit_key(in_item.dig[1]);
      keys_new[5]  = cfk_pkg::digit_key(in_item.dig[0]);
      keys_new[6]  = in_item.odd ? cfk_pkg::KEY_FIVE : cfk_pkg::KEY_NONE;
      keys_new[7]  = cfk_pkg::KEY_GAP;
      keys_new[8]  = cfk_pkg::KEY_Z;
      keys_new[9]  = cfk_pkg::KEY_O;
      keys_new[10] = cfk_pkg::KEY_L;
      keys_new[11] = cfk_pkg::KEY_L;
      keys_new[12] = cfk_pkg::KEY_RETURN;
    end else begin
      keys_new[1]  = in_item.nz[4] ? cfk_pkg::digit_key(in_item.dig[4]) : cfk_pkg::KEY_NONE;
      keys_new[2]  = in_item.nz[3] ? cfk_pkg::digit_key(in_item.dig[3]) : cfk_pkg::KEY_NONE;
      keys_new[3]  = cfk_pkg::digit_key(in_item.dig[2]);
      keys_new[4]  = cfk_pkg::KEY_DECSEP;
      keys_new[5]  = cfk_pkg::digit_key(in_item.dig[1]);
      keys_new[6]  = cfk_pkg::digit_key(in_item.dig[0]);
      keys_new[7]  = cfk_pkg::KEY_GAP;
      keys_new[8]  = cfk_pkg::KEY_M;
      keys_new[9]  = cfk_pkg::KEY_M;
      keys_new[10] = cfk_pkg::KEY_RETURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      if (rej_q) begin
        key_code        <= cfk_pkg::KEY_NONE;
        report_modifier <= '0;
        frame_rejected  <= 1'b1;
        last            <= 1'b1;
      end else if (!phase) begin
        key_code        <= keys[0];
        report_modifier <= modifier_byte;
        frame_rejected  <= 1'b0;
        last            <= 1'b0;
      end else begin
        key_code        <= cfk_pkg::KEY_NONE;
        report_modifier <= '0;
        frame_rejected  <= 1'b0;
        last            <= (remain == '0);
      end
    end
    if (load) begin
      rej_q  <= in_item.rej;
      phase  <= 1'b0;
      remain <= in_item.inch ? cfk_pkg::CNT_W'(cfk_pkg::INCH_KEYS - 1)
                             : cfk_pkg::CNT_W'(cfk_pkg::METRIC_KEYS - 1);
      keys   <= keys_new;
    end else if (busy && adv && !rej_q) begin
      if (!phase) begin
        phase <= 1'b1;
      end else begin
        phase  <= 1'b0;
        remain <= remain - 1'b1;
        for (int i = 0; i < cfk_pkg::INCH_KEYS - 1; i++) begin
          keys[i] <= keys[i+1];
        end
        keys[cfk_pkg::INCH_KEYS-1] <= cfk_pkg::KEY_NONE;
      end
    end
  end

endmodule

`default_nettype wire
